/* hw/rtl/bphd_pkg.sv */
package bphd_pkg;

  // fixed field widths
  localparam int RAW_W   = 10;
  localparam int VAL_W   = 8;
  localparam int BAND_W  = 3;
  localparam int SHIFT   = 2;
  localparam int CFG_IDX_W = 1;

  // register reset values
  localparam logic [VAL_W-1:0] DECAY_RESET = 8'd7;
  localparam logic [VAL_W-1:0] FLOOR_RESET = 8'd40;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 1'b1;

  // item action codes
  localparam logic ACT_RESTART = 1'b0;
  localparam logic ACT_SAMPLE  = 1'b1;

  // one result transaction
  typedef struct packed {
    logic              valid_res;
    logic [BAND_W-1:0] band;
    logic [VAL_W-1:0]  scaled_left;
    logic [VAL_W-1:0]  scaled_right;
    logic [VAL_W-1:0]  held_left;
    logic [VAL_W-1:0]  held_right;
    logic              last_band;
  } res_t;

endpackage

/* hw/rtl/bphd_lane.sv */
module bphd_lane
  import bphd_pkg::*;
#(
  parameter int NUM_BANDS = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  logic [BAND_W-1:0] band_index,
  input  logic [RAW_W-1:0]  raw,
  input  logic [VAL_W-1:0]  decay_step,
  input  logic [VAL_W-1:0]  noise_floor,
  output logic [VAL_W-1:0]  scaled,
  output logic [VAL_W-1:0]  held_next
);

  localparam int IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  logic [VAL_W-1:0] held [NUM_BANDS];
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] cur;
  logic [VAL_W-1:0] decayed;

  assign idx    = band_index[IDX_W-1:0];
  assign scaled = raw[RAW_W-1:SHIFT];
  assign cur    = held[idx];

  // decay with floor at zero, then raise to the new peak if it is above the noise floor
  always_comb begin
    decayed = (cur > decay_step) ? cur - decay_step : '0;
    if (scaled > noise_floor && scaled > decayed) begin
      held_next = scaled;
    end else begin
      held_next = decayed;
    end
  end

  // per-band held values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        held[i] <= '0;
      end
    end else if (upd) begin
      held[idx] <= held_next;
    end
  end

endmodule

/* hw/rtl/bphd_merge.sv */
module bphd_merge
  import bphd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output res_t head
);

  logic [1:0] count;
  logic [1:0] count_next;
  res_t       tail;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);

  // occupancy of the two-entry result queue
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
      end else if (push) begin
        head <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= din;
      end else begin
        tail <= din;
      end
    end
  end

endmodule

/* hw/rtl/band_peak_hold_decay.sv */
// a result is written into the result queue when its sample transaction is taken
// throughput: one item per cycle while sample_stall is low; the held value of a band is read, updated
// and written back in that cycle by each channel lane
// a two-entry result queue lets sampling go on while one result waits
// reset: band index 0, all held values 0, decay_step 7, noise_floor 40
module band_peak_hold_decay
  import bphd_pkg::*;
#(
  parameter int NUM_BANDS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic                 action,
  input  logic [RAW_W-1:0]     raw_left,
  input  logic [RAW_W-1:0]     raw_right,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 valid_res,
  output logic [BAND_W-1:0]    band,
  output logic [VAL_W-1:0]     scaled_left,
  output logic [VAL_W-1:0]     scaled_right,
  output logic [VAL_W-1:0]     held_left,
  output logic [VAL_W-1:0]     held_right,
  output logic                 last_band,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  logic [VAL_W-1:0]  decay_step;
  logic [VAL_W-1:0]  noise_floor;
  logic [BAND_W-1:0] band_index;
  logic              accept;
  logic              in_range;
  logic              upd;
  logic              full;
  logic              pop;
  logic [VAL_W-1:0]  sl;
  logic [VAL_W-1:0]  sr;
  logic [VAL_W-1:0]  hl;
  logic [VAL_W-1:0]  hr;
  res_t              res;
  res_t              head;

  assign cfg_ready    = 1'b1;
  assign sample_stall = full;
  assign accept       = sample_valid && !sample_stall;
  assign in_range     = (band_index < BAND_W'(NUM_BANDS));
  assign upd          = accept && (action == ACT_SAMPLE) && in_range;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_step  <= DECAY_RESET;
      noise_floor <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DECAY_STEP:  decay_step  <= cfg_data;
        REG_NOISE_FLOOR: noise_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  // band scan counter, saturates at the band count
  always_ff @(posedge clk) begin
    if (rst) begin
      band_index <= '0;
    end else if (accept) begin
      if (action == ACT_RESTART) begin
        band_index <= '0;
      end else if (in_range) begin
        band_index <= band_index + BAND_W'(1);
      end
    end
  end

  // one lane per channel
  bphd_lane #(.NUM_BANDS(NUM_BANDS)) u_lane_left (
    .clk         (clk),
    .rst         (rst),
    .upd         (upd),
    .band_index  (band_index),
    .raw         (raw_left),
    .decay_step  (decay_step),
    .noise_floor (noise_floor),
    .scaled      (sl),
    .held_next   (hl)
  );

  bphd_lane #(.NUM_BANDS(NUM_BANDS)) u_lane_right (
    .clk         (clk),
    .rst         (rst),
    .upd         (upd),
    .band_index  (band_index),
    .raw         (raw_right),
    .decay_step  (decay_step),
    .noise_floor (noise_floor),
    .scaled      (sr),
    .held_next   (hr)
  );

  // combine lane results; a sample past the last band reports all zeros
  always_comb begin
    res = '0;
    if (in_range) begin
      res.valid_res    = 1'b1;
      res.band         = band_index;
      res.scaled_left  = sl;
      res.scaled_right = sr;
      res.held_left    = hl;
      res.held_right   = hr;
      res.last_band    = (band_index == BAND_W'(NUM_BANDS - 1));
    end
  end

  assign pop = result_valid && !result_stall;

  bphd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && (action == ACT_SAMPLE)),
    .din        (res),
    .pop        (pop),
    .full       (full),
    .head_valid (result_valid),
    .head       (head)
  );

  assign valid_res    = head.valid_res;
  assign band         = head.band;
  assign scaled_left  = head.scaled_left;
  assign scaled_right = head.scaled_right;
  assign held_left    = head.held_left;
  assign held_right   = head.held_right;
  assign last_band    = head.last_band;

endmodule

/* test/tb_top.sv */
module tb_top;
  import bphd_pkg::*;

  localparam int NUM_BANDS  = 7;
  localparam int LONG_HOLD  = 80;
  localparam int SETTLE     = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  logic                 action = ACT_RESTART;
  logic [RAW_W-1:0]     raw_left = '0;
  logic [RAW_W-1:0]     raw_right = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 valid_res;
  logic [BAND_W-1:0]    band;
  logic [VAL_W-1:0]     scaled_left;
  logic [VAL_W-1:0]     scaled_right;
  logic [VAL_W-1:0]     held_left;
  logic [VAL_W-1:0]     held_right;
  logic                 last_band;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  // shadow state of the peak hold
  logic [VAL_W-1:0] decay_shadow = DECAY_RESET;
  logic [VAL_W-1:0] floor_shadow = FLOOR_RESET;
  logic [VAL_W-1:0] peak_left_shadow [NUM_BANDS];
  logic [VAL_W-1:0] peak_right_shadow [NUM_BANDS];
  int               scan_band = 0;
  res_t             expected_bands [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_count = 0;
  int items_sent = 0;
  int mismatch_count = 0;

  band_peak_hold_decay #(
    .NUM_BANDS(NUM_BANDS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .action       (action),
    .raw_left     (raw_left),
    .raw_right    (raw_right),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .valid_res    (valid_res),
    .band         (band),
    .scaled_left  (scaled_left),
    .scaled_right (scaled_right),
    .held_left    (held_left),
    .held_right   (held_right),
    .last_band    (last_band),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // held value after decay and a possible raise
  function automatic logic [VAL_W-1:0] decayed_peak(input logic [VAL_W-1:0] held,
                                                    input logic [VAL_W-1:0] level);
    logic [VAL_W-1:0] d;
    d = (held > decay_shadow) ? held - decay_shadow : '0;
    if (level > floor_shadow && level > d) begin
      d = level;
    end
    return d;
  endfunction

  // update shadow state for one accepted item, queue its result if any
  task automatic predict_band_sample(input logic act, input logic [RAW_W-1:0] left,
                                     input logic [RAW_W-1:0] right);
    res_t             r;
    logic [VAL_W-1:0] sl;
    logic [VAL_W-1:0] sr;
    sl = VAL_W'(left >> SHIFT);
    sr = VAL_W'(right >> SHIFT);
    r = '0;
    if (act == ACT_RESTART) begin
      scan_band = 0;
    end else if (scan_band >= NUM_BANDS) begin
      expected_bands.push_back(r);
    end else begin
      peak_left_shadow[scan_band]  = decayed_peak(peak_left_shadow[scan_band], sl);
      peak_right_shadow[scan_band] = decayed_peak(peak_right_shadow[scan_band], sr);
      r.valid_res    = 1'b1;
      r.band         = BAND_W'(scan_band);
      r.scaled_left  = sl;
      r.scaled_right = sr;
      r.held_left    = peak_left_shadow[scan_band];
      r.held_right   = peak_right_shadow[scan_band];
      r.last_band    = (scan_band == NUM_BANDS - 1);
      expected_bands.push_back(r);
      scan_band++;
    end
  endtask

  // result side: random stall, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served  <= hold_requests;
      hold_count   <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count   <= hold_count - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  // compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    res_t exp;
    if (!rst && result_valid && !result_stall) begin
      if (expected_bands.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual band %0d", $time, band);
        mismatch_count++;
      end else begin
        exp = expected_bands.pop_front();
        check_field("valid_res", exp.valid_res, valid_res);
        check_field("band", exp.band, band);
        check_field("scaled_left", exp.scaled_left, scaled_left);
        check_field("scaled_right", exp.scaled_right, scaled_right);
        check_field("held_left", exp.held_left, held_left);
        check_field("held_right", exp.held_right, held_right);
        check_field("last_band", exp.last_band, last_band);
      end
    end
  end

  // offer one item and wait for it to be taken
  task automatic send_item(input logic act, input logic [RAW_W-1:0] left,
                           input logic [RAW_W-1:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    action       <= act;
    raw_left     <= left;
    raw_right    <= right;
    do @(posedge clk); while (sample_stall);
    predict_band_sample(act, left, right);
    items_sent++;
  endtask

  // stop offering and let every expected result come out
  task automatic wait_results_drained();
    sample_valid <= 1'b0;
    while (expected_bands.size() != 0) @(posedge clk);
  endtask

  // write both registers while the block is idle
  task automatic write_registers(input logic [VAL_W-1:0] decay,
                                 input logic [VAL_W-1:0] noise);
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? REG_DECAY_STEP : REG_NOISE_FLOOR;
      cfg_data  <= (i == 0) ? decay : noise;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid    <= 1'b0;
    decay_shadow  = decay;
    floor_shadow  = noise;
  endtask

  // reading biased toward the noise floor and the extremes
  function automatic logic [RAW_W-1:0] random_raw();
    int v;
    case ($urandom_range(3))
      0, 1: v = $urandom_range(1023);
      2: v = (int'(floor_shadow) + $urandom_range(4) - 2) * 4 + $urandom_range(3);
      default: v = $urandom_range(1) ? 1023 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return RAW_W'(v);
  endfunction

  // one scan: restart then a run of samples, sometimes short of or past the last band, or at times a lone random item
  task automatic send_scan();
    int n;
    int pick;
    if ($urandom_range(99) < 8) begin
      send_item(logic'($urandom_range(1)), random_raw(), random_raw());
      return;
    end
    send_item(ACT_RESTART, random_raw(), random_raw());
    pick = $urandom_range(99);
    if (pick < 70) n = NUM_BANDS;
    else if (pick < 85) n = $urandom_range(1, NUM_BANDS - 1);
    else n = NUM_BANDS + $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      send_item(ACT_SAMPLE, random_raw(), random_raw());
    end
  endtask

  // reset defaults, field extremes, floor edge, past last band, restart
  task automatic test_directed();
    send_item(ACT_SAMPLE, 10'd1023, 10'd0);
    send_item(ACT_SAMPLE, 10'd163, 10'd164);
    send_item(ACT_SAMPLE, 10'd3, 10'd4);
    send_item(ACT_SAMPLE, 10'h2AA, 10'h155);
    send_item(ACT_SAMPLE, 10'h155, 10'h2AA);
    send_item(ACT_SAMPLE, 10'd1022, 10'd1021);
    send_item(ACT_SAMPLE, 10'd600, 10'd1023);
    send_item(ACT_SAMPLE, 10'd1023, 10'd1023);
    send_item(ACT_SAMPLE, 10'd500, 10'd500);
    send_item(ACT_RESTART, 10'd1023, 10'd1023);
    send_item(ACT_SAMPLE, 10'd0, 10'd0);
    send_item(ACT_SAMPLE, 10'd0, 10'd0);
    send_item(ACT_RESTART, 10'd0, 10'd0);
    send_item(ACT_SAMPLE, 10'd1023, 10'd168);
    send_item(ACT_RESTART, 10'd0, 10'd0);
    send_item(ACT_RESTART, 10'd0, 10'd0);
    send_item(ACT_SAMPLE, 10'd4, 10'd1020);
    send_item(ACT_SAMPLE, 10'd164, 10'd160);
    // heavy decay takes held values to zero
    write_registers(8'd255, 8'd0);
    send_item(ACT_RESTART, 10'd0, 10'd0);
    send_item(ACT_SAMPLE, 10'd0, 10'd3);
    send_item(ACT_SAMPLE, 10'd7, 10'd4);
    send_item(ACT_SAMPLE, 10'd0, 10'd0);
  endtask

  // register extremes, each followed by a few scans
  task automatic test_register_extremes();
    logic [VAL_W-1:0] decays [4] = '{8'd0, 8'd255, 8'd0, 8'd255};
    logic [VAL_W-1:0] floors [4] = '{8'd0, 8'd255, 8'd255, 8'd0};
    send_idle_pct = 10;
    recv_idle_pct = 10;
    for (int k = 0; k < 4; k++) begin
      write_registers(decays[k], floors[k]);
      repeat (3) send_scan();
    end
  endtask

  // random scans under each idling pattern and random register settings
  task automatic test_random_traffic();
    int send_pct [3] = '{26, 46, 0};
    int recv_pct [3] = '{46, 26, 0};
    int stop_at;
    for (int p = 0; p < 3; p++) begin
      write_registers($urandom_range(99) < 70 ? VAL_W'($urandom_range(24))
                                              : VAL_W'($urandom_range(255)),
                      VAL_W'($urandom_range(255)));
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      stop_at = items_sent + 240;
      while (items_sent < stop_at) begin
        send_scan();
      end
    end
  endtask

  // long result hold fills the block, then a pause until all results are out, then scans with random result stalls
  task automatic test_backpressure();
    write_registers(DECAY_RESET, FLOOR_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (6) send_scan();
    wait_results_drained();
    recv_idle_pct = 30;
    repeat (4) send_scan();
  endtask

  initial begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      peak_left_shadow[i]  = '0;
      peak_right_shadow[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
